[rtl/ofb_pkg.sv]
package ofb_pkg;

   localparam int STORE_DEPTH_DEF  = 4096;
   localparam int SAMPLE_BITS_DEF  = 32;
   localparam int MAX_CHANNELS_DEF = 8;

   localparam int PORT_SAMPLE_BITS = 32;
   localparam int CFG_LEN_BITS     = 13;
   localparam int CFG_CH_BITS      = 4;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 13;
   localparam int FRAMES_BITS      = 13;
   localparam int FRAMES_SAT       = 4096;

   localparam logic [CFG_LEN_BITS-1:0] FRAME_LENGTH_RST  = 13'd512;
   localparam logic [CFG_LEN_BITS-1:0] HOP_LENGTH_RST    = 13'd256;
   localparam logic [CFG_CH_BITS-1:0]  CHANNEL_COUNT_RST = 4'd1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FRAME = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_LENGTH  = 2'd0,
      CSR_HOP_LENGTH    = 2'd1,
      CSR_CHANNEL_COUNT = 2'd2,
      CSR_PAD_MODE      = 2'd3
   } csr_index_type;

   // Effective configuration, with zero and out-of-range values already folded.
   typedef struct packed {
      logic [CFG_LEN_BITS-1:0] len_eff;
      logic [CFG_LEN_BITS-1:0] hop_eff;
      logic [CFG_CH_BITS-1:0]  ch_eff;
      logic                    drop_mode;
      logic                    clear;
   } cfg_type;

   // Result fields that travel alongside the store read.
   typedef struct packed {
      logic                   zero;
      logic                   last;
      status_type             status;
      logic [FRAMES_BITS-1:0] frames;
   } meta_type;

endpackage

[rtl/ofb_ram.sv]
module ofb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/ofb_cfg.sv]
module ofb_cfg #(
   parameter int MAX_CHANNELS = ofb_pkg::MAX_CHANNELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ofb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ofb_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output ofb_pkg::cfg_type                   cfg
);

   localparam int CHW = ofb_pkg::CFG_CH_BITS + 1;

   logic [ofb_pkg::CFG_LEN_BITS-1:0] frame_length_ff, frame_length_in;
   logic [ofb_pkg::CFG_LEN_BITS-1:0] hop_length_ff, hop_length_in;
   logic [ofb_pkg::CFG_CH_BITS-1:0]  channel_count_ff, channel_count_in;
   logic                             pad_mode_ff, pad_mode_in;
   logic                             wr_fire;

   assign csr_ready = 1'b1;
   assign wr_fire   = csr_valid && csr_ready;

   always_comb begin
      frame_length_in  = frame_length_ff;
      hop_length_in    = hop_length_ff;
      channel_count_in = channel_count_ff;
      pad_mode_in      = pad_mode_ff;
      if (wr_fire) begin
         unique case (ofb_pkg::csr_index_type'(csr_index))
            ofb_pkg::CSR_FRAME_LENGTH: begin
               frame_length_in = csr_wdata[ofb_pkg::CFG_LEN_BITS-1:0];
            end
            ofb_pkg::CSR_HOP_LENGTH: begin
               hop_length_in = csr_wdata[ofb_pkg::CFG_LEN_BITS-1:0];
            end
            ofb_pkg::CSR_CHANNEL_COUNT: begin
               channel_count_in = csr_wdata[ofb_pkg::CFG_CH_BITS-1:0];
            end
            ofb_pkg::CSR_PAD_MODE: begin
               pad_mode_in = csr_wdata[0];
            end
            default: begin
               pad_mode_in = pad_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff  <= ofb_pkg::FRAME_LENGTH_RST;
         hop_length_ff    <= ofb_pkg::HOP_LENGTH_RST;
         channel_count_ff <= ofb_pkg::CHANNEL_COUNT_RST;
         pad_mode_ff      <= 1'b0;
      end else begin
         frame_length_ff  <= frame_length_in;
         hop_length_ff    <= hop_length_in;
         channel_count_ff <= channel_count_in;
         pad_mode_ff      <= pad_mode_in;
      end
   end

   always_comb begin
      cfg.len_eff = (frame_length_ff == '0) ? ofb_pkg::CFG_LEN_BITS'(1) : frame_length_ff;
      cfg.hop_eff = (hop_length_ff == '0) ? ofb_pkg::CFG_LEN_BITS'(1) : hop_length_ff;
      if (channel_count_ff == '0) begin
         cfg.ch_eff = ofb_pkg::CFG_CH_BITS'(1);
      end else if (CHW'(channel_count_ff) > CHW'(MAX_CHANNELS)) begin
         cfg.ch_eff = ofb_pkg::CFG_CH_BITS'(MAX_CHANNELS);
      end else begin
         cfg.ch_eff = channel_count_ff;
      end
      cfg.drop_mode = pad_mode_ff;
      cfg.clear     = wr_fire;
   end

endmodule

[rtl/ofb_ctrl.sv]
module ofb_ctrl #(
   parameter int STORE_DEPTH  = ofb_pkg::STORE_DEPTH_DEF,
   parameter int SAMPLE_BITS  = ofb_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_CHANNELS = ofb_pkg::MAX_CHANNELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ofb_pkg::cfg_type               cfg,
   input  logic                           fire,
   input  logic                           action,
   input  logic [SAMPLE_BITS-1:0]         sample,
   output logic                           mem_we,
   output logic [$clog2(STORE_DEPTH)-1:0] mem_waddr,
   output logic [SAMPLE_BITS-1:0]         mem_wdata,
   output logic                           mem_re,
   output logic [$clog2(STORE_DEPTH)-1:0] mem_raddr,
   output ofb_pkg::meta_type              meta
);

   localparam int AW  = $clog2(STORE_DEPTH);
   localparam int CW  = $clog2(STORE_DEPTH + 1);
   localparam int TW  = $clog2(((2 ** ofb_pkg::CFG_LEN_BITS) - 1) * MAX_CHANNELS + 1);
   localparam int MW  = ((CW > TW) ? CW : TW) + 1;
   localparam int FW  = ((CW + 1) > ofb_pkg::FRAMES_BITS) ? (CW + 1) : ofb_pkg::FRAMES_BITS;
   localparam int LW  = ofb_pkg::CFG_LEN_BITS;
   localparam int HW  = ofb_pkg::CFG_CH_BITS;

   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] stored_ff, stored_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [HW-1:0] rem_ff, rem_in;
   logic          ge_ff, ge_in;
   logic [CW-1:0] q_ff, q_in;
   logic [LW-1:0] r2_ff, r2_in;
   logic          active_ff, active_in;
   logic [TW-1:0] offset_ff, offset_in;
   logic [TW-1:0] vsamp_ff, vsamp_in;
   logic [TW-1:0] skip_ff, skip_in;

   logic [TW-1:0] total, adv, off, off1, vs;
   logic [AW:0]   rsum, asum, wsum;
   logic          start, act;
   logic [FW-1:0] q_plus;

   always_comb begin
      total = TW'(cfg.len_eff) * TW'(cfg.ch_eff);
      adv   = TW'(cfg.hop_eff) * TW'(cfg.ch_eff);
   end

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      stored_in = stored_ff;
      steps_in  = steps_ff;
      rem_in    = rem_ff;
      ge_in     = ge_ff;
      q_in      = q_ff;
      r2_in     = r2_ff;
      active_in = active_ff;
      offset_in = offset_ff;
      vsamp_in  = vsamp_ff;
      skip_in   = skip_ff;

      meta.zero   = 1'b1;
      meta.last   = 1'b0;
      meta.status = ofb_pkg::STATUS_OK;

      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = wr_idx_ff;
      mem_wdata = sample;

      // A frame starts at its first read if the ring holds enough data.
      start = !active_ff && (ge_ff || (!cfg.drop_mode && (steps_ff != '0)));
      act   = active_ff || start;
      off   = start ? '0 : offset_ff;
      if (start) begin
         vs = (MW'(stored_ff) < MW'(total)) ? TW'(stored_ff) : total;
      end else begin
         vs = vsamp_ff;
      end
      off1 = off + TW'(1);

      rsum = (AW + 1)'(rd_idx_ff) + (AW + 1)'(off);
      if (rsum >= (AW + 1)'(STORE_DEPTH)) begin
         rsum = rsum - (AW + 1)'(STORE_DEPTH);
      end
      mem_raddr = AW'(rsum);

      asum = (AW + 1)'(rd_idx_ff) + (AW + 1)'(adv);
      if (asum >= (AW + 1)'(STORE_DEPTH)) begin
         asum = asum - (AW + 1)'(STORE_DEPTH);
      end

      wsum = (AW + 1)'(wr_idx_ff) + (AW + 1)'(1);
      if (wsum >= (AW + 1)'(STORE_DEPTH)) begin
         wsum = wsum - (AW + 1)'(STORE_DEPTH);
      end

      if (fire) begin
         if (!action) begin
            if (skip_ff != '0) begin
               skip_in = skip_ff - TW'(1);
            end else if (MW'(stored_ff) >= MW'(STORE_DEPTH)) begin
               meta.status = ofb_pkg::STATUS_FULL;
            end else begin
               mem_we    = 1'b1;
               wr_idx_in = AW'(wsum);
               stored_in = stored_ff + CW'(1);
               if (HW'(rem_ff + HW'(1)) == cfg.ch_eff) begin
                  // A full time step completed: steps and the hop quotient move on.
                  rem_in   = '0;
                  steps_in = steps_ff + CW'(1);
                  if (ge_ff) begin
                     if (r2_ff + LW'(1) == cfg.hop_eff) begin
                        q_in  = q_ff + CW'(1);
                        r2_in = '0;
                     end else begin
                        r2_in = r2_ff + LW'(1);
                     end
                  end else if (MW'(steps_ff) + MW'(1) == MW'(cfg.len_eff)) begin
                     ge_in = 1'b1;
                     q_in  = '0;
                     r2_in = '0;
                  end
               end else begin
                  rem_in = rem_ff + HW'(1);
               end
            end
         end else if (!act) begin
            meta.status = ofb_pkg::STATUS_NO_FRAME;
         end else begin
            meta.zero = !(off < vs);
            mem_re    = off < vs;
            if (off1 >= total) begin
               meta.last = 1'b1;
               active_in = 1'b0;
               offset_in = '0;
               vsamp_in  = '0;
               if (MW'(stored_ff) >= MW'(adv)) begin
                  rd_idx_in = AW'(asum);
                  stored_in = stored_ff - CW'(adv);
                  steps_in  = steps_ff - CW'(cfg.hop_eff);
                  if (ge_ff) begin
                     if (q_ff != '0) begin
                        q_in = q_ff - CW'(1);
                     end else begin
                        ge_in = 1'b0;
                        r2_in = '0;
                     end
                  end
               end else begin
                  // The hop runs past the stored data; the rest is skipped on arrival.
                  skip_in   = adv - TW'(stored_ff);
                  rd_idx_in = wr_idx_ff;
                  stored_in = '0;
                  steps_in  = '0;
                  rem_in    = '0;
                  ge_in     = 1'b0;
                  q_in      = '0;
                  r2_in     = '0;
               end
            end else begin
               active_in = 1'b1;
               offset_in = off1;
               vsamp_in  = vs;
            end
         end
      end

      q_plus = FW'(q_in) + FW'(1);
      if (ge_in) begin
         if (q_plus >= FW'(ofb_pkg::FRAMES_SAT)) begin
            meta.frames = ofb_pkg::FRAMES_BITS'(ofb_pkg::FRAMES_SAT);
         end else begin
            meta.frames = ofb_pkg::FRAMES_BITS'(q_plus);
         end
      end else begin
         meta.frames = ofb_pkg::FRAMES_BITS'(!cfg.drop_mode && (steps_in != '0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.clear) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         stored_ff <= '0;
         steps_ff  <= '0;
         rem_ff    <= '0;
         ge_ff     <= 1'b0;
         q_ff      <= '0;
         r2_ff     <= '0;
         active_ff <= 1'b0;
         offset_ff <= '0;
         vsamp_ff  <= '0;
         skip_ff   <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         stored_ff <= stored_in;
         steps_ff  <= steps_in;
         rem_ff    <= rem_in;
         ge_ff     <= ge_in;
         q_ff      <= q_in;
         r2_ff     <= r2_in;
         active_ff <= active_in;
         offset_ff <= offset_in;
         vsamp_ff  <= vsamp_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

[rtl/overlapping_frame_buffer.sv]
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_action, req_sample_in
// rsp       out        rsp_valid/rsp_stall  rsp_sample_out, rsp_frame_last, rsp_status,
//                                           rsp_frames_ready
// csr       in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One transaction per cycle on req while req_stall is low; the ring read register and the
// transaction's result fields load at the accepting edge, and the output register loads
// from them when the read stage advances, which rsp_stall can hold back.
// Reset is synchronous; it restores the register defaults and empties the ring at once.
// The ring contents are not cleared; entries are only read after they are written.
// req_stall rises only while both the read stage and the output register hold results
// and rsp_stall is high, so a held result does not stop the next transaction.
module overlapping_frame_buffer #(
   parameter int STORE_DEPTH  = ofb_pkg::STORE_DEPTH_DEF,
   parameter int SAMPLE_BITS  = ofb_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_CHANNELS = ofb_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [ofb_pkg::PORT_SAMPLE_BITS-1:0] req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ofb_pkg::PORT_SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                                 rsp_frame_last,
   output logic [1:0]                           rsp_status,
   output logic [ofb_pkg::FRAMES_BITS-1:0]      rsp_frames_ready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ofb_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ofb_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int AW = $clog2(STORE_DEPTH);

   ofb_pkg::cfg_type  cfg;
   ofb_pkg::meta_type meta;
   logic              fire;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [SAMPLE_BITS-1:0] mem_wdata, mem_rdata;

   logic              s1_valid_ff, s1_valid_in;
   ofb_pkg::meta_type s1_meta_ff;
   logic              s1_adv;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ofb_pkg::PORT_SAMPLE_BITS-1:0] rsp_sample_out_ff;
   logic              rsp_frame_last_ff;
   ofb_pkg::status_type rsp_status_ff;
   logic [ofb_pkg::FRAMES_BITS-1:0] rsp_frames_ready_ff;

   ofb_cfg #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg)
   );

   ofb_ctrl #(
      .STORE_DEPTH (STORE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .fire     (fire),
      .action   (req_action),
      .sample   (SAMPLE_BITS'(req_sample_in)),
      .mem_we   (mem_we),
      .mem_waddr(mem_waddr),
      .mem_wdata(mem_wdata),
      .mem_re   (mem_re),
      .mem_raddr(mem_raddr),
      .meta     (meta)
   );

   ofb_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(STORE_DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .re   (mem_re),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   // The ring's read register is only reloaded when a new transaction enters,
   // which happens only when the read stage is empty or moving, so it holds while stalled.
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign fire      = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = fire || (s1_valid_ff && !s1_adv);
      rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_meta_ff <= meta;
      end
      if (s1_adv) begin
         rsp_sample_out_ff   <= s1_meta_ff.zero ? '0 :
                                ofb_pkg::PORT_SAMPLE_BITS'(mem_rdata);
         rsp_frame_last_ff   <= s1_meta_ff.last;
         rsp_status_ff       <= s1_meta_ff.status;
         rsp_frames_ready_ff <= s1_meta_ff.frames;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_out   = rsp_sample_out_ff;
   assign rsp_frame_last   = rsp_frame_last_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frames_ready = rsp_frames_ready_ff;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the output side could take a result");

   a_last_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |-> (rsp_status == ofb_pkg::STATUS_OK))
      else $error("frame end marked on a failed transaction");

   a_data_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_sample_out != '0)) |-> (rsp_status == ofb_pkg::STATUS_OK))
      else $error("sample data returned on a failed transaction");

   a_single_ram_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("ring written and read in the same cycle");
`endif

endmodule

[verif/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ofb_pkg::*;

   localparam int unsigned RING_WORDS = STORE_DEPTH_DEF;
   localparam int unsigned CHAN_LIMIT = MAX_CHANNELS_DEF;
   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [PORT_SAMPLE_BITS-1:0] sample;
      logic                        last;
      status_type                  status;
      logic [FRAMES_BITS-1:0]      frames;
   } frame_reply_type;

   class frame_scoreboard;
      logic [CFG_LEN_BITS-1:0]     cfg_frame_length;
      logic [CFG_LEN_BITS-1:0]     cfg_hop_length;
      logic [CFG_CH_BITS-1:0]      cfg_channel_count;
      logic                        cfg_pad_mode;
      logic [PORT_SAMPLE_BITS-1:0] ring [RING_WORDS];
      int unsigned wr_ptr, rd_ptr, held_words, frame_pos, frame_words, skip_words;
      bit          in_frame;
      frame_reply_type pending_replies[$];
      int unsigned errors, replies_seen, frames_done, drops, empty_reads, config_writes;

      function new();
         cfg_frame_length  = FRAME_LENGTH_RST;
         cfg_hop_length    = HOP_LENGTH_RST;
         cfg_channel_count = CHANNEL_COUNT_RST;
         cfg_pad_mode      = 1'b0;
         clear_ring();
      endfunction

      function void clear_ring();
         wr_ptr      = 0;
         rd_ptr      = 0;
         held_words  = 0;
         frame_pos   = 0;
         frame_words = 0;
         skip_words  = 0;
         in_frame    = 0;
      endfunction

      function int unsigned eff_length();
         return (cfg_frame_length == 0) ? 1 : cfg_frame_length;
      endfunction

      function int unsigned eff_hop();
         return (cfg_hop_length == 0) ? 1 : cfg_hop_length;
      endfunction

      function int unsigned eff_channels();
         int unsigned c;
         c = (cfg_channel_count == 0) ? 1 : cfg_channel_count;
         return (c > CHAN_LIMIT) ? CHAN_LIMIT : c;
      endfunction

      function int unsigned words_per_frame();
         return eff_length() * eff_channels();
      endfunction

      function int unsigned frames_on_hand();
         int unsigned steps, n;
         steps = held_words / eff_channels();
         if (steps < eff_length())
            return (!cfg_pad_mode && steps > 0) ? 1 : 0;
         n = (steps - eff_length()) / eff_hop() + 1;
         return (n > FRAMES_SAT) ? FRAMES_SAT : n;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_FRAME_LENGTH:  cfg_frame_length  = value;
            CSR_HOP_LENGTH:    cfg_hop_length    = value;
            CSR_CHANNEL_COUNT: cfg_channel_count = value[CFG_CH_BITS-1:0];
            CSR_PAD_MODE:      cfg_pad_mode      = value[0];
         endcase
         config_writes++;
         clear_ring();
      endfunction

      function void absorb_request(logic act, logic [PORT_SAMPLE_BITS-1:0] smp);
         frame_reply_type r;
         int unsigned  total, advance;
         r.sample = '0;
         r.last   = 1'b0;
         r.status = STATUS_OK;
         if (act == ACT_PUSH) begin
            if (skip_words > 0) begin
               skip_words--;
            end else if (held_words >= RING_WORDS) begin
               r.status = STATUS_FULL;
               drops++;
            end else begin
               ring[wr_ptr] = smp;
               wr_ptr = (wr_ptr + 1) % RING_WORDS;
               held_words++;
            end
         end else begin
            total = words_per_frame();
            if (!in_frame && frames_on_hand() > 0) begin
               in_frame    = 1;
               frame_pos   = 0;
               frame_words = (held_words < total) ? held_words : total;
            end
            if (!in_frame) begin
               r.status = STATUS_NO_FRAME;
               empty_reads++;
            end else begin
               // Words past what was stored when the frame opened read as zero.
               if (frame_pos < frame_words)
                  r.sample = ring[(rd_ptr + frame_pos) % RING_WORDS];
               frame_pos++;
               if (frame_pos >= total) begin
                  advance     = eff_hop() * eff_channels();
                  r.last      = 1'b1;
                  in_frame    = 0;
                  frame_pos   = 0;
                  frame_words = 0;
                  frames_done++;
                  if (held_words >= advance) begin
                     rd_ptr = (rd_ptr + advance) % RING_WORDS;
                     held_words -= advance;
                  end else begin
                     // The rest of the hop is taken out of samples yet to arrive.
                     skip_words = advance - held_words;
                     rd_ptr     = wr_ptr;
                     held_words = 0;
                  end
               end
            end
         end
         r.frames = FRAMES_BITS'(frames_on_hand());
         pending_replies.push_back(r);
      endfunction

      function void check_reply(logic [PORT_SAMPLE_BITS-1:0] smp, logic last,
                                logic [1:0] st, logic [FRAMES_BITS-1:0] frames);
         frame_reply_type e;
         if (pending_replies.size() == 0) begin
            $error("result with no transaction outstanding: sample_out %h", smp);
            errors++;
            return;
         end
         e = pending_replies.pop_front();
         replies_seen++;
         if (smp !== e.sample) begin
            $error("sample_out expected %h actual %h", e.sample, smp);
            errors++;
         end
         if (last !== e.last) begin
            $error("frame_last expected %0d actual %0d", e.last, last);
            errors++;
         end
         if (st !== e.status) begin
            $error("status expected %0d actual %0d", e.status, st);
            errors++;
         end
         if (frames !== e.frames) begin
            $error("frames_ready expected %0d actual %0d", e.frames, frames);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = ACT_PUSH;
   logic [PORT_SAMPLE_BITS-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [PORT_SAMPLE_BITS-1:0] rsp_sample_out;
   logic rsp_frame_last;
   logic [1:0] rsp_status;
   logic [FRAMES_BITS-1:0] rsp_frames_ready;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   idle_mode_type idle_mode = IDLE_NONE;
   logic hold_req = 1'b0;
   bit hold_taken = 0;
   int unsigned hold_left = 0;
   int unsigned sent_total = 0;

   frame_scoreboard board = new();

   overlapping_frame_buffer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample_out(rsp_sample_out),
      .rsp_frame_last(rsp_frame_last),
      .rsp_status(rsp_status),
      .rsp_frames_ready(rsp_frames_ready),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 75;
         IDLE_BOTH:   return $urandom_range(99) < 37;
         default:     return 0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(99) < 75;
         IDLE_BOTH:     return $urandom_range(99) < 37;
         default:       return 0;
      endcase
   endfunction

   // Result side: check at the edge where a transaction completes, then pick the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_reply(rsp_sample_out, rsp_frame_last, rsp_status, rsp_frames_ready);
      if (hold_req && !hold_taken) begin
         hold_taken = 1;
         hold_left  = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= receiver_stalls();
      end
   end

   task automatic send_item(input logic act, input logic [PORT_SAMPLE_BITS-1:0] smp);
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_sample_in <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.absorb_request(act, smp);
      sent_total++;
   endtask

   task automatic send_run(input logic act, input int unsigned count);
      repeat (count) send_item(act, $urandom);
   endtask

   task automatic settle();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (board.pending_replies.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_register(idx, value);
   endtask

   task automatic configure(input int unsigned len, input int unsigned hop,
                            input int unsigned ch, input bit pad);
      settle();
      write_csr(CSR_FRAME_LENGTH, CSR_DATA_BITS'(len));
      write_csr(CSR_HOP_LENGTH, CSR_DATA_BITS'(hop));
      write_csr(CSR_CHANNEL_COUNT, CSR_DATA_BITS'(ch));
      write_csr(CSR_PAD_MODE, CSR_DATA_BITS'(pad));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly runs of pushes and frame reads sized to the current frame, with some noise.
   task automatic run_phase(input int unsigned n_items, input bit pressure);
      int unsigned sent, burst, total;
      bit          noise, paused;
      logic        act;
      sent   = 0;
      paused = 0;
      while (sent < n_items) begin
         total = board.words_per_frame();
         act   = 1'($urandom_range(1));
         noise = ($urandom_range(9) == 0);
         if (noise)
            burst = 1 + $urandom_range(3);
         else
            burst = 1 + $urandom_range(act ? total + 1 : 2 * total);
         if (burst > n_items - sent)
            burst = n_items - sent;
         repeat (burst) begin
            if (noise) act = 1'($urandom_range(1));
            send_item(act, $urandom);
            sent++;
         end
         if (pressure && sent >= n_items / 3)
            hold_req <= 1'b1;
         if (pressure && !paused && hold_taken && hold_left == 0 && sent >= 2 * n_items / 3) begin
            settle();
            paused = 1;
         end
      end
   endtask

   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Short zero-padded frame, then a hop longer than the data on hand.
      configure(4, 6, 1, 0);
      send_item(ACT_READ, '0);
      send_item(ACT_PUSH, 32'h0000_0000);
      send_item(ACT_PUSH, 32'hFFFF_FFFF);
      send_run(ACT_READ, 4);
      send_item(ACT_PUSH, 32'hA5A5_A5A5);
      send_item(ACT_PUSH, 32'h5A5A_5A5A);
      send_run(ACT_PUSH, 3);
      send_run(ACT_READ, 4);

      // Zero lengths act as one and an oversized channel count clamps to the maximum.
      configure(0, 0, 15, 1);
      send_run(ACT_PUSH, 7);
      send_item(ACT_READ, '0);
      send_item(ACT_PUSH, 32'hFFFF_FFFF);
      send_run(ACT_READ, 8);

      for (int p = 0; p < 8; p++) begin
         idle_mode <= idle_mode_type'(p % 4);
         configure($urandom_range(12), $urandom_range(20), $urandom_range(15),
                   1'($urandom_range(1)));
         run_phase(200, p == 4);
      end

      // A zero-padded frame longer than the store, read past its data, with pushes
      // arriving while it is open.
      idle_mode <= IDLE_RECEIVER;
      configure(8191, 8191, 1, 0);
      send_run(ACT_PUSH, 3);
      send_run(ACT_READ, 10);
      send_run(ACT_PUSH, 4);

      // In drop mode a frame that cannot fit is never offered.
      idle_mode <= IDLE_BOTH;
      configure(8191, 1, 8, 1);
      send_run(ACT_PUSH, 20);
      send_run(ACT_READ, 3);

      settle();
      repeat (8) @(posedge clock);
      if (board.pending_replies.size() != 0) begin
         $error("%0d expected results never arrived", board.pending_replies.size());
         board.errors++;
      end
      $display("Covered %0d transactions over %0d register writes: %0d frames read out,",
               sent_total, board.config_writes, board.frames_done);
      $display("%0d samples dropped on a full store, %0d reads with no frame ready.",
               board.drops, board.empty_reads);
      if (board.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
